// ----- design/bda_pkg.sv -----
// Shared constants for the binary to decimal ASCII unit.
`default_nettype none
package bda_pkg;
   localparam int VALUE_WIDTH        = 64;
   localparam int CHAR_WIDTH         = 8;
   localparam int DEFAULT_VALUE_BITS = 64;
   localparam int DEFAULT_MAX_DIGITS = 20;
   localparam logic [CHAR_WIDTH-1:0] CH_ZERO  = 8'h30;
   localparam logic [CHAR_WIDTH-1:0] CH_NINE  = 8'h39;
   localparam logic [CHAR_WIDTH-1:0] CH_MINUS = 8'h2D;

   typedef enum logic [3:0] {
      ST_IDLE    = 4'b0001,
      ST_CONVERT = 4'b0010,
      ST_SIGN    = 4'b0100,
      ST_EMIT    = 4'b1000
   } state_type;
endpackage
`default_nettype wire

// ----- design/binary_to_decimal_ascii_unit.sv -----
// Binary to decimal ASCII converter: shift-and-add-3 core and character emitter.
//
// Usage: a request on req_ carries one number (req_value, low VALUE_BITS bits
// used) and req_signed_mode. The unit answers with its decimal text on rsp_,
// one ASCII character per transfer, most significant digit first, leading
// zeros dropped, a single '0' for zero, and '-' first for a negative signed
// number. rsp_last_char marks the final character of each number.
// Operation: the magnitude enters the BCD shift register one bit per cycle.
// The emitter then sends a '-' for a negative number, drops each leading zero
// without using the output register and sends each remaining digit.
// req_ready is high only while no number is in work; the next request is taken
// as soon as the final character sits in the output register, even if the
// receiver has not taken it yet.
// A stalled receiver freezes the sending of characters, though leading zeros
// are still dropped; the output register holds its character until rsp_ready.
// Reset drops any number in work and empties the output register.
`default_nettype none
module binary_to_decimal_ascii_unit #(
   parameter int VALUE_BITS = bda_pkg::DEFAULT_VALUE_BITS,
   parameter int MAX_DIGITS = bda_pkg::DEFAULT_MAX_DIGITS
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_ready,
   input  wire logic [bda_pkg::VALUE_WIDTH-1:0] req_value,
   input  wire logic                           req_signed_mode,
   output logic                                rsp_valid,
   input  wire logic                           rsp_ready,
   output logic [bda_pkg::CHAR_WIDTH-1:0]      rsp_text_char,
   output logic                                rsp_last_char
);
   import bda_pkg::*;

   localparam int BCD_BITS  = 4 * MAX_DIGITS;
   localparam int BIT_CNT_W = $clog2(VALUE_BITS);
   localparam int DIG_CNT_W = $clog2(MAX_DIGITS + 1);

   state_type               state_ff, state_in;
   logic [VALUE_BITS-1:0]   mag_ff, mag_in;
   logic [BCD_BITS-1:0]     bcd_ff, bcd_in;
   logic [BIT_CNT_W-1:0]    bit_cnt_ff, bit_cnt_in;
   logic [DIG_CNT_W-1:0]    dig_cnt_ff, dig_cnt_in;
   logic                    neg_ff, neg_in;
   logic                    started_ff, started_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [CHAR_WIDTH-1:0]   rsp_char_ff, rsp_char_in;
   logic                    rsp_last_ff, rsp_last_in;

   logic [VALUE_BITS-1:0]   req_bits;
   logic                    req_neg;
   logic [BCD_BITS-1:0]     bcd_adj;
   logic [3:0]              top_digit;
   logic                    out_free;
   logic                    final_digit;

   assign req_bits    = req_value[VALUE_BITS-1:0];
   assign req_neg     = req_signed_mode & req_bits[VALUE_BITS-1];
   assign top_digit   = bcd_ff[BCD_BITS-1 -: 4];
   assign out_free    = !rsp_valid_ff || rsp_ready;
   assign final_digit = (dig_cnt_ff == DIG_CNT_W'(1));

   // add 3 to every digit of 5 or more before the shift
   always_comb begin
      for (int d = 0; d < MAX_DIGITS; d++) begin
         bcd_adj[4*d +: 4] = (bcd_ff[4*d +: 4] >= 4'd5) ? bcd_ff[4*d +: 4] + 4'd3
                                                       : bcd_ff[4*d +: 4];
      end
   end

   always_comb begin
      state_in     = state_ff;
      mag_in       = mag_ff;
      bcd_in       = bcd_ff;
      bit_cnt_in   = bit_cnt_ff;
      dig_cnt_in   = dig_cnt_ff;
      neg_in       = neg_ff;
      started_in   = started_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_char_in  = rsp_char_ff;
      rsp_last_in  = rsp_last_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               mag_in     = req_neg ? (~req_bits + VALUE_BITS'(1)) : req_bits;
               neg_in     = req_neg;
               bcd_in     = '0;
               bit_cnt_in = BIT_CNT_W'(VALUE_BITS - 1);
               state_in   = ST_CONVERT;
            end
         end
         ST_CONVERT: begin
            bcd_in     = {bcd_adj[BCD_BITS-2:0], mag_ff[VALUE_BITS-1]};
            mag_in     = {mag_ff[VALUE_BITS-2:0], 1'b0};
            bit_cnt_in = bit_cnt_ff - BIT_CNT_W'(1);
            if (bit_cnt_ff == '0) begin
               dig_cnt_in = DIG_CNT_W'(MAX_DIGITS);
               started_in = 1'b0;
               state_in   = neg_ff ? ST_SIGN : ST_EMIT;
            end
         end
         ST_SIGN: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = CH_MINUS;
               rsp_last_in  = 1'b0;
               state_in     = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (!started_ff && top_digit == 4'd0 && !final_digit) begin
               // drop a leading zero without using the output slot
               bcd_in     = {bcd_ff[BCD_BITS-5:0], 4'd0};
               dig_cnt_in = dig_cnt_ff - DIG_CNT_W'(1);
            end else if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = CH_ZERO + {4'd0, top_digit};
               rsp_last_in  = final_digit;
               started_in   = 1'b1;
               bcd_in       = {bcd_ff[BCD_BITS-5:0], 4'd0};
               dig_cnt_in   = dig_cnt_ff - DIG_CNT_W'(1);
               if (final_digit) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      mag_ff     <= mag_in;
      bcd_ff     <= bcd_in;
      bit_cnt_ff <= bit_cnt_in;
      dig_cnt_ff <= dig_cnt_in;
      neg_ff     <= neg_in;
      started_ff <= started_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign req_ready     = (state_ff == ST_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_text_char = rsp_char_ff;
   assign rsp_last_char = rsp_last_ff;
endmodule
`default_nettype wire

// ----- design/bda_checker.sv -----
// Port-level checks for the binary to decimal ASCII unit, bound to the top level.
`default_nettype none
module bda_checker (
   input wire logic                           clock,
   input wire logic                           reset,
   input wire logic                           req_valid,
   input wire logic                           req_ready,
   input wire logic [bda_pkg::VALUE_WIDTH-1:0] req_value,
   input wire logic                           req_signed_mode,
   input wire logic                           rsp_valid,
   input wire logic                           rsp_ready,
   input wire logic [bda_pkg::CHAR_WIDTH-1:0]  rsp_text_char,
   input wire logic                           rsp_last_char
);
   import bda_pkg::*;

   // a waiting request holds
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid && $stable(req_value)
                                  && $stable(req_signed_mode))
      else $error("waiting request changed");

   // a stalled character holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_text_char)
                                  && $stable(rsp_last_char))
      else $error("stalled response changed");

   // an accepted request keeps the unit busy while it converts
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while conversion in progress");

   a_char_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_text_char == CH_MINUS)
                    || (rsp_text_char >= CH_ZERO && rsp_text_char <= CH_NINE))
      else $error("illegal output character");

   a_sign_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_text_char == CH_MINUS |-> !rsp_last_char)
      else $error("sign marked as final character");
endmodule

bind binary_to_decimal_ascii_unit bda_checker u_bda_checker (.*);
`default_nettype wire

// ----- bench/testbench.sv -----
// Self-checking testbench for the binary to decimal ASCII unit.
module testbench;
   import bda_pkg::*;

   localparam int CYCLE_LIMIT   = 1_000_000;
   localparam int DRAIN_CYCLES  = 120;
   localparam int RANDOM_ITEMS  = 248;

   typedef struct {
      logic [VALUE_WIDTH-1:0] value;
      logic                   signed_mode;
   } number_request_type;

   typedef struct {
      logic [CHAR_WIDTH-1:0] ch;
      logic                  last;
   } text_char_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_ready;
   logic [VALUE_WIDTH-1:0]  req_value = '0;
   logic                    req_signed_mode = 1'b0;
   logic                    rsp_valid;
   logic                    rsp_ready = 1'b0;
   logic [CHAR_WIDTH-1:0]   rsp_text_char;
   logic                    rsp_last_char;

   number_request_type pending_numbers[$];
   text_char_type      expected_text[$];
   int              error_count = 0;
   int              cycle_count = 0;
   int              req_gap_left = 0;
   int              req_calm_left = 0;
   int              rsp_stall_left = 0;
   int              rsp_calm_left = 0;

   binary_to_decimal_ascii_unit i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_value       (req_value),
      .req_signed_mode (req_signed_mode),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_text_char   (rsp_text_char),
      .rsp_last_char   (rsp_last_char)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   task automatic report_mismatch(input string msg);
      $display("mismatch at cycle %0d: %s", cycle_count, msg);
      error_count++;
   endtask

   // Append the decimal text of one number to the expected characters.
   function automatic void predict_text(input logic [VALUE_WIDTH-1:0] value,
                                        input logic signed_mode);
      logic [VALUE_WIDTH-1:0] magnitude;
      logic                   negative;
      logic [3:0]             digit [DEFAULT_MAX_DIGITS];
      int                     ndigits;
      text_char_type          tc;
      negative  = signed_mode && value[VALUE_WIDTH-1];
      magnitude = negative ? (~value + 1'b1) : value;
      ndigits   = 1;
      for (int i = 0; i < DEFAULT_MAX_DIGITS; i++) begin
         digit[i]  = 4'(magnitude % 10);
         magnitude = magnitude / 10;
         if (digit[i] != 4'd0) ndigits = i + 1;
      end
      if (negative) begin
         tc.ch   = CH_MINUS;
         tc.last = 1'b0;
         expected_text.push_back(tc);
      end
      for (int i = ndigits - 1; i >= 0; i--) begin
         tc.ch   = CH_ZERO + CHAR_WIDTH'(digit[i]);
         tc.last = (i == 0);
         expected_text.push_back(tc);
      end
   endfunction

   function automatic logic [VALUE_WIDTH-1:0] random_word();
      return {$urandom, $urandom};
   endfunction

   function automatic logic [VALUE_WIDTH-1:0] power_of_ten(input int exponent);
      logic [VALUE_WIDTH-1:0] p;
      p = 64'd1;
      repeat (exponent) p = p * 10;
      return p;
   endfunction

   task automatic push_number(input logic [VALUE_WIDTH-1:0] value, input logic signed_mode);
      number_request_type n;
      n.value       = value;
      n.signed_mode = signed_mode;
      pending_numbers.push_back(n);
   endtask

   // Mix of digit counts, decade boundaries, negatives and extremes.
   task automatic push_random_number();
      int                     roll;
      logic [VALUE_WIDTH-1:0] v;
      roll = $urandom_range(0, 99);
      if (roll < 30) begin
         push_number(random_word(), 1'($urandom));
      end else if (roll < 55) begin
         v = random_word() >> $urandom_range(0, 63);
         push_number(v, 1'($urandom));
      end else if (roll < 70) begin
         v = power_of_ten($urandom_range(0, 19)) + 64'($urandom_range(0, 2)) - 64'd1;
         push_number(v, 1'($urandom));
      end else if (roll < 85) begin
         v = random_word() >> $urandom_range(40, 63);
         push_number(-v, 1'b1);
      end else if (roll < 95) begin
         push_number(64'($urandom_range(0, 20)), 1'($urandom));
      end else begin
         case ($urandom_range(0, 3))
            0: v = 64'd0;
            1: v = '1;
            2: v = 64'h8000_0000_0000_0000;
            default: v = 64'h7FFF_FFFF_FFFF_FFFF;
         endcase
         push_number(v, 1'($urandom));
      end
   endtask

   function automatic int next_request_gap();
      int roll;
      if (req_calm_left > 0) begin
         req_calm_left--;
         return 0;
      end
      roll = $urandom_range(0, 99);
      if (roll < 5) begin
         req_calm_left = $urandom_range(8, 25);
         return 0;
      end
      if (roll < 55) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(15, 60);
   endfunction

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("simulation failed");
         $finish;
      end
   end

   always @(posedge clock) begin : request_driver
      number_request_type n;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) predict_text(req_value, req_signed_mode);
         if (!req_valid || req_ready) begin
            if (req_gap_left > 0) begin
               req_gap_left <= req_gap_left - 1;
               req_valid    <= 1'b0;
            end else if (pending_numbers.size() > 0) begin
               n = pending_numbers.pop_front();
               req_value       <= n.value;
               req_signed_mode <= n.signed_mode;
               req_valid       <= 1'b1;
               req_gap_left    <= next_request_gap();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : response_pacing
      int roll;
      roll = $urandom_range(0, 99);
      if (rsp_stall_left > 0) begin
         rsp_stall_left <= rsp_stall_left - 1;
         rsp_ready      <= 1'b0;
      end else if (rsp_calm_left > 0) begin
         rsp_calm_left <= rsp_calm_left - 1;
         rsp_ready     <= 1'b1;
      end else if (roll < 2) begin
         rsp_stall_left <= $urandom_range(8, 30);
         rsp_ready      <= 1'b0;
      end else if (roll < 25) begin
         rsp_stall_left <= $urandom_range(0, 2);
         rsp_ready      <= 1'b0;
      end else if (roll < 28) begin
         rsp_calm_left <= $urandom_range(20, 80);
         rsp_ready     <= 1'b1;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin : text_monitor
      text_char_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_text.size() == 0) begin
            report_mismatch($sformatf("unexpected char %h last %b",
                                      rsp_text_char, rsp_last_char));
         end else begin
            want = expected_text.pop_front();
            if (rsp_text_char !== want.ch)
               report_mismatch($sformatf("text_char %h, want %h", rsp_text_char, want.ch));
            if (rsp_last_char !== want.last)
               report_mismatch($sformatf("last_char %b, want %b (char %h)",
                                         rsp_last_char, want.last, want.ch));
         end
      end
   end

   initial begin
      // zero, single digits and decade edges
      push_number(64'd0, 1'b0);
      push_number(64'd0, 1'b1);
      push_number(64'd1, 1'b0);
      push_number(64'd9, 1'b1);
      push_number(64'd10, 1'b0);
      push_number(64'd99, 1'b0);
      push_number(64'd100, 1'b1);
      push_number(64'd123456789, 1'b0);
      // full-range unsigned: 19 and 20 digits
      push_number('1, 1'b0);
      push_number(64'd10_000_000_000_000_000_000, 1'b0);
      push_number(64'd9_999_999_999_999_999_999, 1'b0);
      push_number(64'h8000_0000_0000_0000, 1'b0);
      // signed: -1, most negative, most positive, small negatives; plus unsigned most positive and bit patterns
      push_number('1, 1'b1);
      push_number(64'h8000_0000_0000_0000, 1'b1);
      push_number(64'h7FFF_FFFF_FFFF_FFFF, 1'b1);
      push_number(64'h7FFF_FFFF_FFFF_FFFF, 1'b0);
      push_number(-64'd10, 1'b1);
      push_number(-64'd9, 1'b1);
      push_number(-64'd100, 1'b1);
      push_number(64'h8000_0000_0000_0001, 1'b1);
      push_number(64'h5555_5555_5555_5555, 1'b1);
      push_number(64'hAAAA_AAAA_AAAA_AAAA, 1'b0);
      for (int i = 0; i < RANDOM_ITEMS; i++) push_random_number();

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      while (pending_numbers.size() > 0 || req_valid) @(posedge clock);
      while (expected_text.size() > 0) @(posedge clock);
      // catch any stray characters after the last expected one
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_count == 0 && expected_text.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end
endmodule
